// ===== rtl/tlg_pkg.sv =====
// Shared types and constants for the two-colour life grid step block.
// No dependencies.
package tlg_pkg;

  typedef logic [1:0] cell_t;

  localparam cell_t CELL_DEAD = 2'd0;
  localparam cell_t CELL_RED  = 2'd1;
  localparam cell_t CELL_BLUE = 2'd2;
  localparam cell_t CELL_BAD  = 2'd3;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  localparam logic [1:0] REG_ROWS     = 2'd0;
  localparam logic [1:0] REG_COLS     = 2'd1;
  localparam logic [1:0] REG_TOPOLOGY = 2'd2;

  localparam int PADDR_W = 4;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] row;
    logic [5:0] col;
    cell_t      cell_value;
  } req_t;

  typedef struct packed {
    cell_t read_value;
    logic  step_done;
  } rsp_t;

endpackage

// ===== rtl/two_colour_life_grid_step.sv =====
// Two-colour life grid: cell store in two banks, cell read/write and generation step.
// Depends on tlg_pkg.
//
//   channel  direction  payload        handshake
//   in       input      tlg_pkg::req_t in_valid_i / in_stall_o
//   out      output     tlg_pkg::rsp_t out_valid_o / out_stall_i
//   cfg      input      APB write/read psel, penable, pwrite, pready
//
// Write: the cell is written and the response registered when the item is taken. Read: the
// memory read is registered, then S_RDQ registers the result. Step: each of the MAX_ROWS*MAX_COLS
// entries passes S_NB (nine reads through one port) and S_WB (write-back); cells outside the area in use are copied.
// After reset a clearing pass over all MAX_ROWS*MAX_COLS entries zeroes both banks; no item is
// taken meanwhile. Items are refused while a result waits under stall.
module two_colour_life_grid_step #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tlg_pkg::req_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tlg_pkg::rsp_t                out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlg_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RDQ, S_NB, S_WB} state_e;

  state_e          state_q;
  logic [AW-1:0]   clr_q;
  logic            cur_q;
  logic [6:0]      grid_rows_q, grid_cols_q;
  logic            topology_q;
  logic [RIW-1:0]  ri_q;
  logic [CIW-1:0]  ci_q;
  logic [3:0]      nb_q;
  logic [3:0]      red_q, blue_q;
  tlg_pkg::cell_t  self_q;
  logic            rd_inside_q;
  logic            out_valid_q;
  tlg_pkg::rsp_t   out_data_q;

  tlg_pkg::cell_t  mem_a [DEPTH];
  tlg_pkg::cell_t  mem_b [DEPTH];
  tlg_pkg::cell_t  rd_a_q, rd_b_q, rdata;
  logic [AW-1:0]   raddr, waddr;
  tlg_pkg::cell_t  wdata;
  logic            we_a, we_b;

  logic [RW-1:0]   rows_use;
  logic [CW-1:0]   cols_use;
  logic            in_acc, cfg_wr, req_inside, cell_inside, last_cell;
  logic [AW-1:0]   req_addr, cell_addr, nbr_addr;
  logic [RW-1:0]   nr;
  logic [CW-1:0]   nc;
  logic            crossed;
  logic [3:0]      live;
  tlg_pkg::cell_t  new_cell;

  // sizes in use
  always_comb begin
    if (grid_rows_q < 7'd3) rows_use = RW'(3);
    else if (int'(grid_rows_q) > MAX_ROWS) rows_use = RW'(MAX_ROWS);
    else rows_use = RW'(grid_rows_q);
    if (grid_cols_q < 7'd3) cols_use = CW'(3);
    else if (int'(grid_cols_q) > MAX_COLS) cols_use = CW'(MAX_COLS);
    else cols_use = CW'(grid_cols_q);
  end

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;

  assign req_inside = (32'(in_data_i.row) < 32'(rows_use)) && (32'(in_data_i.col) < 32'(cols_use));
  assign req_addr   = AW'(AW'(in_data_i.row) * AW'(MAX_COLS) + AW'(in_data_i.col));

  assign cell_inside = (RW'(ri_q) < rows_use) && (CW'(ci_q) < cols_use);
  assign cell_addr   = AW'(AW'(ri_q) * AW'(MAX_COLS) + AW'(ci_q));
  assign last_cell   = (ri_q == RIW'(MAX_ROWS - 1)) && (ci_q == CIW'(MAX_COLS - 1));

  assign rdata = cur_q ? rd_b_q : rd_a_q;

  // neighbour address for slot nb_q of the 3x3 window, row-major, slot 4 is the cell itself
  always_comb begin
    logic up, dn, lt, rt;
    up = (nb_q == 4'd0) || (nb_q == 4'd1) || (nb_q == 4'd2);
    dn = (nb_q == 4'd6) || (nb_q == 4'd7) || (nb_q == 4'd8);
    lt = (nb_q == 4'd0) || (nb_q == 4'd3) || (nb_q == 4'd6);
    rt = (nb_q == 4'd2) || (nb_q == 4'd5) || (nb_q == 4'd8);
    crossed = 1'b0;
    nr = RW'(ri_q);
    if (up) begin
      if (ri_q == '0) begin
        nr = rows_use - RW'(1);
        crossed = 1'b1;
      end else begin
        nr = RW'(ri_q) - RW'(1);
      end
    end else if (dn) begin
      if (RW'(ri_q) == rows_use - RW'(1)) begin
        nr = '0;
        crossed = 1'b1;
      end else begin
        nr = RW'(ri_q) + RW'(1);
      end
    end
    nc = CW'(ci_q);
    if (lt) begin
      nc = (ci_q == '0) ? cols_use - CW'(1) : CW'(ci_q) - CW'(1);
    end else if (rt) begin
      nc = (CW'(ci_q) == cols_use - CW'(1)) ? '0 : CW'(ci_q) + CW'(1);
    end
    // Klein bottle: mirror the column when the row wraps
    if (topology_q && crossed) nc = cols_use - CW'(1) - nc;
    if (cell_inside) nbr_addr = AW'(AW'(nr) * AW'(MAX_COLS) + AW'(nc));
    else nbr_addr = cell_addr;
  end

  // next state of the swept cell
  assign live = red_q + blue_q;
  always_comb begin
    new_cell = self_q;
    if (cell_inside) begin
      if (self_q == tlg_pkg::CELL_DEAD) begin
        if (live == 4'd3) new_cell = (blue_q > red_q) ? tlg_pkg::CELL_BLUE : tlg_pkg::CELL_RED;
        else if (live == 4'd6 && red_q > blue_q) new_cell = tlg_pkg::CELL_RED;
        else new_cell = tlg_pkg::CELL_DEAD;
      end else if (live != 4'd2 && live != 4'd3) begin
        new_cell = tlg_pkg::CELL_DEAD;
      end
    end
  end

  // memory port control; steps read the current bank and write the other one
  always_comb begin
    raddr = req_addr;
    waddr = cell_addr;
    wdata = new_cell;
    we_a  = 1'b0;
    we_b  = 1'b0;
    unique case (state_q)
      S_CLR: begin
        waddr = clr_q;
        wdata = tlg_pkg::CELL_DEAD;
        we_a  = 1'b1;
        we_b  = 1'b1;
      end
      S_IDLE: begin
        if (in_acc && in_data_i.req_type == tlg_pkg::REQ_WRITE && req_inside) begin
          waddr = req_addr;
          wdata = (in_data_i.cell_value == tlg_pkg::CELL_BAD) ? tlg_pkg::CELL_DEAD
                                                              : in_data_i.cell_value;
          we_a  = !cur_q;
          we_b  = cur_q;
        end
      end
      S_NB: raddr = nbr_addr;
      S_WB: begin
        we_a = cur_q;
        we_b = !cur_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[waddr] <= wdata;
    if (we_b) mem_b[waddr] <= wdata;
    rd_a_q <= mem_a[raddr];
    rd_b_q <= mem_b[raddr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= 7'd60;
      grid_cols_q <= 7'd30;
      topology_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tlg_pkg::REG_ROWS:     grid_rows_q <= pwdata[6:0];
        tlg_pkg::REG_COLS:     grid_cols_q <= pwdata[6:0];
        tlg_pkg::REG_TOPOLOGY: topology_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tlg_pkg::REG_ROWS:     prdata = {25'd0, grid_rows_q};
      tlg_pkg::REG_COLS:     prdata = {25'd0, grid_cols_q};
      tlg_pkg::REG_TOPOLOGY: prdata = {31'd0, topology_q};
      default:               prdata = '0;
    endcase
  end

  // control state machine and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      cur_q       <= 1'b0;
      ri_q        <= '0;
      ci_q        <= '0;
      nb_q        <= '0;
      red_q       <= '0;
      blue_q      <= '0;
      self_q      <= tlg_pkg::CELL_DEAD;
      rd_inside_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_data_i.req_type)
              tlg_pkg::REQ_READ: begin
                rd_inside_q <= req_inside;
                state_q     <= S_RDQ;
              end
              tlg_pkg::REQ_STEP: begin
                ri_q    <= '0;
                ci_q    <= '0;
                nb_q    <= '0;
                state_q <= S_NB;
              end
              default: begin
                out_valid_q <= 1'b1;
                out_data_q  <= '{read_value: tlg_pkg::CELL_DEAD, step_done: 1'b0};
              end
            endcase
          end
        end
        S_RDQ: begin
          out_valid_q <= 1'b1;
          out_data_q  <= '{read_value: rd_inside_q ? rdata : tlg_pkg::CELL_DEAD,
                           step_done: 1'b0};
          state_q     <= S_IDLE;
        end
        S_NB: begin
          // data of slot nb_q-1 arrives in the cycle after its read (registered memory output)
          if (nb_q == 4'd0) begin
            red_q  <= '0;
            blue_q <= '0;
          end else if (nb_q == 4'd5) begin
            self_q <= rdata;
          end else if (rdata == tlg_pkg::CELL_RED) begin
            red_q <= red_q + 4'd1;
          end else if (rdata == tlg_pkg::CELL_BLUE) begin
            blue_q <= blue_q + 4'd1;
          end
          if (nb_q == 4'd9) begin
            nb_q    <= '0;
            state_q <= S_WB;
          end else begin
            nb_q <= nb_q + 4'd1;
          end
        end
        S_WB: begin
          if (last_cell) begin
            cur_q       <= !cur_q;
            out_valid_q <= 1'b1;
            out_data_q  <= '{read_value: tlg_pkg::CELL_DEAD, step_done: 1'b1};
            state_q     <= S_IDLE;
          end else begin
            if (ci_q == CIW'(MAX_COLS - 1)) begin
              ci_q <= '0;
              ri_q <= ri_q + RIW'(1);
            end else begin
              ci_q <= ci_q + CIW'(1);
            end
            state_q <= S_NB;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("item taken while busy");

  a_step_swaps_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && last_cell) |=> (cur_q != $past(cur_q)) && out_data_q.step_done)
    else $error("step end did not swap banks");

  a_nb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NB) |-> (nb_q <= 4'd9)) else $error("window slot out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDQ) |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a waiting one");

endmodule
